FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the unpacker RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcu assertion failed");

// Next-cycle implication.
`define PCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcu assertion failed");

`endif

FILE: hw/rtl/pcu_pkg.sv
`default_nettype none

package pcu_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_GRAY_MAXIMUM = 3'd1;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_GLYPH_ROWS   = 3'd3;
  localparam logic [2:0] CFG_ROW_PITCH    = 3'd4;

  // pixel format codes
  localparam logic [1:0] FMT_1BPP = 2'd0;
  localparam logic [1:0] FMT_2BPP = 2'd1;
  localparam logic [1:0] FMT_4BPP = 2'd2;
  localparam logic [1:0] FMT_8BPP = 2'd3;

  localparam logic [10:0] FIELD_LIMIT = 11'd1024;
  localparam logic [3:0]  DIV_STEPS   = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]  fmt;
    logic [1:0]  shamt;   // log2 of pixels per byte
    logic [7:0]  maxv;    // 8-bit mode divisor
    logic [10:0] pitch;
    logic [10:0] rows;
    logic [10:0] width;
    logic        empty;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcu_cfg_regs.sv
`default_nettype none

module pcu_cfg_regs
  import pcu_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [10:0] wr_data,
  output cfg_t             cfg
);

  localparam int          LIMIT_INT   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [10:0] WIDTH_LIMIT = 11'(LIMIT_INT);

  logic [1:0]  pixel_format_r;
  logic [7:0]  gray_maximum_r;
  logic [10:0] glyph_width_r;
  logic [10:0] glyph_rows_r;
  logic [10:0] row_pitch_r;

  logic [10:0] pitch;
  logic [10:0] width_a;
  logic [13:0] pitch_px;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_8BPP;
      gray_maximum_r <= 8'd255;
      glyph_width_r  <= 11'd0;
      glyph_rows_r   <= 11'd0;
      row_pitch_r    <= 11'd1;
    end else if (wr_en) begin
      case (wr_index)
        CFG_PIXEL_FORMAT: pixel_format_r <= wr_data[1:0];
        CFG_GRAY_MAXIMUM: gray_maximum_r <= wr_data[7:0];
        CFG_GLYPH_WIDTH:  glyph_width_r  <= wr_data;
        CFG_GLYPH_ROWS:   glyph_rows_r   <= wr_data;
        CFG_ROW_PITCH:    row_pitch_r    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_pitch_r == 11'd0) begin
      pitch = 11'd1;
    end else if (row_pitch_r > FIELD_LIMIT) begin
      pitch = FIELD_LIMIT;
    end else begin
      pitch = row_pitch_r;
    end
    width_a  = (glyph_width_r > WIDTH_LIMIT) ? WIDTH_LIMIT : glyph_width_r;
    pitch_px = 14'(pitch) << (~pixel_format_r);

    cfg.fmt   = pixel_format_r;
    cfg.shamt = ~pixel_format_r;
    cfg.maxv  = (gray_maximum_r == 8'd0) ? 8'd255 : gray_maximum_r;
    cfg.pitch = pitch;
    cfg.rows  = (glyph_rows_r > FIELD_LIMIT) ? FIELD_LIMIT : glyph_rows_r;
    cfg.width = (14'(width_a) > pitch_px) ? pitch_px[10:0] : width_a;
    cfg.empty = (glyph_width_r == 11'd0) || (glyph_rows_r == 11'd0);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pcu_divider.sv
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor * 256 so the quotient fits 8 bits.
module pcu_divider
  import pcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [7:0]  divisor,
  output div_stat_t        stat,
  output logic [7:0]       quotient
);

  logic [7:0] rem_r;
  logic [7:0] num_r;
  logic [7:0] q_r;
  logic [3:0] cnt_r;
  logic       done_r;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  assign trial = {rem_r, num_r[7]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_STEPS;
      done_r <= 1'b0;
    end else if (cnt_r != 4'd0) begin
      cnt_r  <= cnt_r - 4'd1;
      done_r <= (cnt_r == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[15:8];
      num_r <= dividend[7:0];
      q_r   <= 8'd0;
    end else if (cnt_r != 4'd0) begin
      rem_r <= fits ? diff[7:0] : trial[7:0];
      num_r <= {num_r[6:0], 1'b0};
      q_r   <= {q_r[6:0], fits};
    end
  end

  assign stat.busy = (cnt_r != 4'd0);
  assign stat.done = done_r;
  assign quotient  = q_r;

  `PCU_ASSERT_NEXT(a_start_busy, start, stat.busy)
  `PCU_ASSERT_SAME(a_done_idle, stat.done, !stat.busy)

endmodule

`default_nettype wire

FILE: hw/rtl/packed_coverage_unpacker.sv
// Packed coverage unpacker: turns a 1/2/4/8 bpp glyph bitmap into 8-bit
// coverage pixels, one output item per pixel.
// Input channel (in_*): one source byte per item, rows of row_pitch bytes.
// Output channel (out_*): coverage, column and last-of-byte / end-of-row /
// end-of-glyph flags. Padding bytes and samples past the width produce nothing.
// Config channel (cfg_*): index/data writes, always ready; write only when idle.
// Timing: a byte is taken while the sequencer is idle, then pixels leave the
// sequencer one per cycle into the output register while the output is not
// stalled. In 8 bpp mode the scale by the gray maximum runs through a serial
// divider unless the sample saturates. A padding byte emits nothing. The first
// pixel goes from the byte registers through the output register; in 8 bpp it
// waits for the divider first.
// in_stall is high while a byte is being worked on; a stalled output holds
// its item and the sequencer waits for it to drain.
// Reset (synchronous, active low) restores register defaults, clears the
// row/byte counters and drops any pending output.
`default_nettype none

`include "assert_macros.svh"

module packed_coverage_unpacker
  import pcu_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_source_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_coverage,
  output logic [9:0]       out_column,
  output logic             out_last_of_byte,
  output logic             out_end_of_row,
  output logic             out_end_of_glyph,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  cfg_t      cfg;
  div_stat_t div_stat;
  logic [7:0] quotient;

  state_t      state_r, state_nxt;
  logic [9:0]  byte_in_row_r, byte_in_row_nxt;
  logic [9:0]  row_index_r, row_index_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [12:0] base_r, base_nxt;
  logic        last_row_r, last_row_nxt;

  logic        out_valid_r;
  logic [7:0]  out_coverage_r;
  logic [9:0]  out_column_r;
  logic        out_last_of_byte_r;
  logic        out_end_of_row_r;
  logic        out_end_of_glyph_r;

  logic        in_accept;
  logic        byte_end;
  logic        last_row;
  logic [12:0] base_now;
  logic [13:0] col;
  logic [13:0] col_p1;
  logic [13:0] width14;
  logic        k_last;
  logic        pix_last;
  logic        pix_eor;
  logic        out_free;
  logic        need_div;
  logic [15:0] dividend;
  logic [7:0]  cov_fast;
  logic [7:0]  sh_shifted;
  logic        div_start;
  logic        load;
  logic [7:0]  load_cov;
  logic        load_last;

  assign cfg_ready = 1'b1;

  pcu_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pcu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cfg.maxv),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);

  assign byte_end = {1'b0, byte_in_row_r} >= (cfg.pitch - 11'd1);
  assign last_row = {1'b0, row_index_r} >= (cfg.rows - 11'd1);
  assign base_now = 13'(byte_in_row_r) << cfg.shamt;

  assign col      = {1'b0, base_r} + 14'(k_r);
  assign col_p1   = col + 14'd1;
  assign width14  = 14'(cfg.width);
  assign k_last   = (k_r == (3'd7 >> cfg.fmt));
  assign pix_last = k_last || (col_p1 >= width14);
  assign pix_eor  = (col == width14 - 14'd1);
  assign out_free = !out_valid_r || !out_stall;

  // sample >= max saturates, so the divider only sees quotients below 256
  assign need_div = (cfg.fmt == FMT_8BPP) && (sh_r < cfg.maxv);
  assign dividend = {sh_r, 8'h00} - {8'h00, sh_r};

  // packed modes: sample*255/(2^bpp-1) is bit replication
  always_comb begin
    case (cfg.fmt)
      FMT_1BPP: begin
        cov_fast   = {8{sh_r[7]}};
        sh_shifted = {sh_r[6:0], 1'b0};
      end
      FMT_2BPP: begin
        cov_fast   = {4{sh_r[7:6]}};
        sh_shifted = {sh_r[5:0], 2'b00};
      end
      FMT_4BPP: begin
        cov_fast   = {2{sh_r[7:4]}};
        sh_shifted = {sh_r[3:0], 4'h0};
      end
      default: begin
        cov_fast   = 8'hFF;
        sh_shifted = 8'h00;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    byte_in_row_nxt = byte_in_row_r;
    row_index_nxt   = row_index_r;
    sh_nxt          = sh_r;
    k_nxt           = k_r;
    base_nxt        = base_r;
    last_row_nxt    = last_row_r;
    div_start       = 1'b0;
    load            = 1'b0;
    load_cov        = cov_fast;
    load_last       = pix_last;

    case (state_r)
      S_IDLE: begin
        if (in_accept && !cfg.empty) begin
          if (byte_end) begin
            byte_in_row_nxt = 10'd0;
            row_index_nxt   = last_row ? 10'd0 : row_index_r + 10'd1;
          end else begin
            byte_in_row_nxt = byte_in_row_r + 10'd1;
          end
          sh_nxt       = in_source_byte;
          k_nxt        = 3'd0;
          base_nxt     = base_now;
          last_row_nxt = last_row;
          // padding byte: nothing to emit
          if (base_now < 13'(cfg.width)) begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (need_div) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (out_free) begin
          load = 1'b1;
          if (pix_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt  = k_r + 3'd1;
            sh_nxt = sh_shifted;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done && out_free) begin
          load      = 1'b1;
          load_cov  = quotient;
          load_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      byte_in_row_r <= 10'd0;
      row_index_r   <= 10'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_in_row_r <= byte_in_row_nxt;
      row_index_r   <= row_index_nxt;
      out_valid_r   <= load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    last_row_r <= last_row_nxt;
    if (load) begin
      out_coverage_r     <= load_cov;
      out_column_r       <= col[9:0];
      out_last_of_byte_r <= load_last;
      out_end_of_row_r   <= pix_eor;
      out_end_of_glyph_r <= pix_eor && last_row_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coverage     = out_coverage_r;
  assign out_column       = out_column_r;
  assign out_last_of_byte = out_last_of_byte_r;
  assign out_end_of_row   = out_end_of_row_r;
  assign out_end_of_glyph = out_end_of_glyph_r;

  `PCU_ASSERT_SAME(a_div_wait_live, state_r == S_DIV, div_stat.busy || div_stat.done)
  `PCU_ASSERT_SAME(a_eog_flags, out_valid_r && out_end_of_glyph_r, out_end_of_row_r && out_last_of_byte_r)

endmodule

`default_nettype wire

FILE: bench/tb_packed_coverage_unpacker.sv
`default_nettype none

module tb_packed_coverage_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import pcu_pkg::*;

  localparam int unsigned MAX_W       = 1024;
  localparam int          BYTE_SETTLE = 24;      // covers the slowest byte (8 bpp divide)
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] coverage;
    logic [9:0] column;
    logic       last_of_byte;
    logic       end_of_row;
    logic       end_of_glyph;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_source_byte = 8'd0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_coverage;
  logic [9:0]  out_column;
  logic        out_last_of_byte;
  logic        out_end_of_row;
  logic        out_end_of_glyph;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [10:0] cfg_data = 11'd0;

  // predictor copy of the registers and the position counters
  logic [1:0]  fmt_reg   = FMT_8BPP;
  logic [7:0]  gray_reg  = 8'd255;
  logic [10:0] width_reg = 11'd0;
  logic [10:0] rows_reg  = 11'd0;
  logic [10:0] pitch_reg = 11'd1;
  logic [9:0]  byte_cnt  = 10'd0;
  logic [9:0]  row_cnt   = 10'd0;

  pixel_t pixel_q[$];
  pixel_t want_px;

  int  err_count = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;

  packed_coverage_unpacker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_byte   (in_source_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coverage     (out_coverage),
    .out_column       (out_column),
    .out_last_of_byte (out_last_of_byte),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_glyph (out_end_of_glyph),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= idle_en && ($urandom_range(99) < 37);

  task automatic report_mismatch(input string what);
    if (err_count < 40) $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // expected pixels for one source byte; advances the byte/row counters
  task automatic predict_pixels(input logic [7:0] src);
    int unsigned bpp, ppb, mask, maxv, pitch, rows, width, base, col, shift, sample, cov;
    bit          last_row;
    pixel_t      buf_px[8];
    int          n;
    if (width_reg == 0 || rows_reg == 0) return;
    bpp   = 1 << fmt_reg;
    ppb   = 8 >> fmt_reg;
    mask  = (1 << bpp) - 1;
    maxv  = (fmt_reg == FMT_8BPP) ? ((gray_reg == 0) ? 255 : gray_reg) : mask;
    pitch = (pitch_reg == 0) ? 1 : ((pitch_reg > FIELD_LIMIT) ? FIELD_LIMIT : pitch_reg);
    rows  = (rows_reg > FIELD_LIMIT) ? FIELD_LIMIT : rows_reg;
    width = (width_reg > MAX_W) ? MAX_W : width_reg;
    if (width > FIELD_LIMIT) width = FIELD_LIMIT;
    if (width > pitch * ppb) width = pitch * ppb;
    last_row = (row_cnt >= rows - 1);
    base = byte_cnt * ppb;
    n = 0;
    for (int k = 0; k < ppb; k++) begin
      col = base + k;
      if (col >= width) break;
      shift  = 8 - bpp * (k + 1);
      sample = (src >> shift) & mask;
      cov    = sample * 255 / maxv;
      if (cov > 255) cov = 255;
      buf_px[n].coverage     = cov[7:0];
      buf_px[n].column       = col[9:0];
      buf_px[n].last_of_byte = 1'b0;
      buf_px[n].end_of_row   = (col == width - 1);
      buf_px[n].end_of_glyph = (col == width - 1) && last_row;
      n++;
    end
    if (n > 0) buf_px[n-1].last_of_byte = 1'b1;
    for (int k = 0; k < n; k++) pixel_q = {pixel_q, buf_px[k]};
    if (byte_cnt >= pitch - 1) begin
      byte_cnt = 10'd0;
      row_cnt  = last_row ? 10'd0 : row_cnt + 10'd1;
    end else begin
      byte_cnt = byte_cnt + 10'd1;
    end
  endtask

  task automatic check_pixel(input pixel_t want);
    if (out_coverage !== want.coverage)
      report_mismatch($sformatf("coverage got %0d want %0d at column %0d",
                                out_coverage, want.coverage, want.column));
    if (out_column !== want.column)
      report_mismatch($sformatf("column got %0d want %0d", out_column, want.column));
    if (out_last_of_byte !== want.last_of_byte)
      report_mismatch($sformatf("last_of_byte got %0b want %0b at column %0d",
                                out_last_of_byte, want.last_of_byte, want.column));
    if (out_end_of_row !== want.end_of_row)
      report_mismatch($sformatf("end_of_row got %0b want %0b at column %0d",
                                out_end_of_row, want.end_of_row, want.column));
    if (out_end_of_glyph !== want.end_of_glyph)
      report_mismatch($sformatf("end_of_glyph got %0b want %0b at column %0d",
                                out_end_of_glyph, want.end_of_glyph, want.column));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PIXEL_FORMAT: fmt_reg   = cfg_data[1:0];
          CFG_GRAY_MAXIMUM: gray_reg  = cfg_data[7:0];
          CFG_GLYPH_WIDTH:  width_reg = cfg_data;
          CFG_GLYPH_ROWS:   rows_reg  = cfg_data;
          CFG_ROW_PITCH:    pitch_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixels(in_source_byte);
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel at column %0d", out_column));
        end else begin
          want_px = pixel_q.pop_front();
          check_pixel(want_px);
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [10:0] fmt, input logic [10:0] gray,
                            input logic [10:0] width, input logic [10:0] rows,
                            input logic [10:0] pitch);
    cfg_write(CFG_PIXEL_FORMAT, fmt);
    cfg_write(CFG_GRAY_MAXIMUM, gray);
    cfg_write(CFG_GLYPH_WIDTH, width);
    cfg_write(CFG_GLYPH_ROWS, rows);
    cfg_write(CFG_ROW_PITCH, pitch);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] value);
    while (idle_en && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // all pixels out, then let any padding byte still in work settle
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(negedge clk); while (pixel_q.size() != 0);
    repeat (BYTE_SETTLE) @(posedge clk);
  endtask

  task automatic test_empty_glyph;
    // reset values: width 0, nothing comes out
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained;
    for (int k = 1; k <= 3; k++) cfg_write(3'(CFG_ROW_PITCH + k), 11'h7FF);
    set_config(FMT_1BPP, 11'd1, 11'd8, 11'd0, 11'd1);
    send_byte(8'hA5);
    wait_drained;
  endtask

  task automatic test_packed_formats;
    // in the 1 and 4 bpp cases the second byte of each row is partly or wholly padding
    set_config(FMT_1BPP, 11'd255, 11'd5, 11'd2, 11'd2);
    send_byte(8'hFF);
    send_byte(8'h81);
    send_byte(8'hAA);
    send_byte(8'h55);
    wait_drained;
    set_config(FMT_2BPP, 11'd255, 11'd4, 11'd1, 11'd1);
    send_byte(8'hE4);
    send_byte(8'h1B);
    wait_drained;
    set_config(FMT_4BPP, 11'd255, 11'd3, 11'd1, 11'd2);
    send_byte(8'hF0);
    send_byte(8'h7A);
    wait_drained;
  endtask

  task automatic test_gray_levels;
    // upper data bits dropped by the narrow registers
    set_config(11'h7FF, 11'h7FF, 11'd1, 11'd1, 11'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained;
    // samples above the maximum saturate
    set_config(FMT_8BPP, 11'd1, 11'd1, 11'd1, 11'd1);
    send_byte(8'h01);
    send_byte(8'hC8);
    wait_drained;
    // zero maximum behaves as 255
    set_config(FMT_8BPP, 11'd0, 11'd1, 11'd1, 11'd1);
    send_byte(8'h80);
    wait_drained;
    set_config(FMT_8BPP, 11'd100, 11'd1, 11'd1, 11'd1);
    send_byte(8'h37);
    send_byte(8'h64);
    wait_drained;
  endtask

  task automatic test_clamped_sizes;
    // width wider than the pitch holds
    set_config(FMT_1BPP, 11'd255, 11'd20, 11'd1, 11'd1);
    send_byte(8'hC3);
    wait_drained;
    // oversize width and rows, zero pitch
    set_config(FMT_8BPP, 11'd255, 11'h7FF, 11'h7FF, 11'd0);
    send_byte(8'h9C);
    wait_drained;
    set_config(FMT_8BPP, 11'd255, 11'd3, 11'h7FF, 11'h7FF);
    send_byte(8'h11);
    send_byte(8'hEE);
    wait_drained;
  endtask

  task automatic test_midglyph_change;
    // counters sit mid-row; shrinking pitch and rows forces row and glyph end
    set_config(FMT_8BPP, 11'd255, 11'd3, 11'd1, 11'd1);
    send_byte(8'h42);
    wait_drained;
    send_byte(8'hBD);
    wait_drained;
  endtask

  task automatic test_wide_row;
    idle_en = 1'b0;
    set_config(FMT_1BPP, 11'd255, 11'h7FF, 11'd1, 11'd128);
    for (int i = 0; i < 128; i++) send_byte(8'($urandom_range(255)));
    wait_drained;
    idle_en = 1'b1;
  endtask

  task automatic test_random_glyphs(input int target);
    int unsigned fmt, ppb, width, rows, need, pitch, gray, nbytes;
    int          sent;
    bit          empty, broken, pause;
    sent = 0;
    while (sent < target) begin
      fmt   = $urandom_range(3);
      ppb   = 8 >> fmt;
      width = ($urandom_range(15) == 0) ? $urandom_range(900, 2047) : $urandom_range(1, 20);
      rows  = $urandom_range(1, 3);
      need  = (((width > FIELD_LIMIT) ? FIELD_LIMIT : width) + ppb - 1) / ppb;
      pitch = need + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
      if ($urandom_range(9) == 0) pitch = $urandom_range(0, need);
      gray  = ($urandom_range(2) == 0) ? 255 : $urandom_range(0, 255);
      empty = ($urandom_range(11) == 0);
      if (empty) begin
        if ($urandom_range(1)) width = 0;
        else rows = 0;
      end
      set_config(11'(fmt), 11'(gray), 11'(width), 11'(rows), 11'(pitch));
      nbytes = ((pitch == 0) ? 1 : pitch) * rows;
      broken = (nbytes > 16) || ($urandom_range(7) == 0);
      if (empty) nbytes = 3;
      else if (broken) nbytes = $urandom_range(1, (nbytes < 16) ? nbytes : 16);
      pause = ($urandom_range(5) == 0);
      for (int i = 0; i < nbytes; i++) begin
        if (pause && i > 0 && i == nbytes / 2) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pixel_q.size() != 0);
          @(posedge clk);
        end
        send_byte(8'($urandom_range(255)));
      end
      if (!empty) sent += nbytes;
      wait_drained;
      if (broken && !empty) begin
        // one-byte, one-row glyph returns the counters to the origin
        set_config(11'(fmt), 11'(gray), 11'd1, 11'd1, 11'd1);
        send_byte(8'($urandom_range(255)));
        sent++;
        wait_drained;
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_glyph;
    test_packed_formats;
    test_gray_levels;
    test_clamped_sizes;
    test_midglyph_change;
    test_wide_row;
    test_random_glyphs(75);
    wait_drained;
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
